// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, masked while reset is applied
`define CHK_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// Concurrent assertion that also covers the reset cycles
`define CHK_ASSERT_ALL(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hw/rtl/blrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrp_pkg
// Types, constants and datapath opcodes for the blacklist remap picker.
// ----------------------------------------------------------------------------
package blrp_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int ENTRY_W       = 16;
  localparam int RANGE_W       = VALUE_BITS + 1;
  localparam int RAND_W        = 31;
  localparam int V_W           = RANGE_W + 1;
  localparam int DIV_CNT_W     = 5;
  localparam int MAX_BLACK_DEF = 64;

  localparam logic [RANGE_W-1:0]   RANGE_CAP = RANGE_W'(1) << VALUE_BITS;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(RAND_W - 1);

  localparam logic [1:0] ST_PICK_OK    = 2'd0;
  localparam logic [1:0] ST_ENTRY_OK   = 2'd1;
  localparam logic [1:0] ST_NO_ALLOWED = 2'd2;
  localparam logic [1:0] ST_STORE_FULL = 2'd3;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_PICK = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [ENTRY_W-1:0] entry_value;
    logic               entry_last;
    logic [RAND_W-1:0]  random_word;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] picked_value;
    logic [1:0]         status;
  } out_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_STORE,
    DP_RANK_LDX,
    DP_RANK_SCAN,
    DP_RANK_WR,
    DP_BUILD,
    DP_SKIP_ADV,
    DP_SKIP_END,
    DP_MAP_ADV,
    DP_MAP_WR,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_SRCH_INIT,
    DP_SRCH_STEP,
    DP_EMIT_LOAD,
    DP_EMIT_EMPTY,
    DP_EMIT_HIT,
    DP_EMIT_MISS
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic op_pick;
    logic last;
    logic m_zero;
    logic allowed_zero;
    logic x_last;
    logic scan_done;
    logic skip_go;
    logic map_done;
    logic map_adv;
    logic div_last;
    logic srch_hit;
    logic srch_done;
  } st_t;

endpackage

// ===== hw/rtl/blrp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrp_ctrl
// Sequencer: decodes each transaction and steps the datapath through
// load, sort, table build, divide and search phases.
// ----------------------------------------------------------------------------
module blrp_ctrl
  import blrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  st_t  st,
  output cmd_t cmd,
  output logic busy,
  output logic cfg_ready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_POST,
    S_RANK_X,
    S_RANK_LDX,
    S_SCAN,
    S_BUILD,
    S_SKIP_RD,
    S_SKIP_CK,
    S_MAP_RD,
    S_MAP_CK,
    S_DIV,
    S_SINIT,
    S_SRCH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = DP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        priority if (!st.op_pick) begin
          cmd.op    = DP_STORE;
          state_nxt = S_POST;
        end else if (st.allowed_zero) begin
          cmd.op    = DP_EMIT_EMPTY;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = DP_DIV_INIT;
          state_nxt = S_DIV;
        end
      end
      S_POST: begin
        priority if (!st.last) begin
          cmd.op    = DP_EMIT_LOAD;
          state_nxt = S_IDLE;
        end else if (st.m_zero) begin
          state_nxt = S_BUILD;
        end else begin
          state_nxt = S_RANK_X;
        end
      end
      S_RANK_X:   state_nxt = S_RANK_LDX;
      S_RANK_LDX: begin
        cmd.op    = DP_RANK_LDX;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          cmd.op    = DP_RANK_WR;
          state_nxt = st.x_last ? S_BUILD : S_RANK_X;
        end else begin
          cmd.op = DP_RANK_SCAN;
        end
      end
      S_BUILD: begin
        cmd.op    = DP_BUILD;
        state_nxt = S_SKIP_RD;
      end
      S_SKIP_RD: state_nxt = S_SKIP_CK;
      S_SKIP_CK: begin
        if (st.skip_go) begin
          cmd.op    = DP_SKIP_ADV;
          state_nxt = S_SKIP_RD;
        end else begin
          cmd.op    = DP_SKIP_END;
          state_nxt = S_MAP_RD;
        end
      end
      S_MAP_RD: begin
        if (st.map_done) begin
          cmd.op    = DP_EMIT_LOAD;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MAP_CK;
        end
      end
      S_MAP_CK: begin
        cmd.op    = st.map_adv ? DP_MAP_ADV : DP_MAP_WR;
        state_nxt = S_MAP_RD;
      end
      S_DIV: begin
        cmd.op = DP_DIV_STEP;
        if (st.div_last) state_nxt = S_SINIT;
      end
      S_SINIT: begin
        cmd.op    = DP_SRCH_INIT;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        priority if (st.srch_hit) begin
          cmd.op    = DP_EMIT_HIT;
          state_nxt = S_IDLE;
        end else if (st.srch_done) begin
          cmd.op    = DP_EMIT_MISS;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = DP_SRCH_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

endmodule

// ===== hw/rtl/blrp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrp_dp
// Datapath: entry store, rank sort, remap table, restoring divider,
// table search and result register.
// ----------------------------------------------------------------------------
module blrp_dp
  import blrp_pkg::*;
#(
  parameter int MAX_BLACK = MAX_BLACK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [RANGE_W-1:0] cfg_data,
  input  in_t                in_data,
  input  cmd_t               cmd,
  output st_t                st,
  output logic               out_valid,
  output out_t               out_data
);

  localparam int AW = (MAX_BLACK > 1) ? $clog2(MAX_BLACK) : 1;
  localparam int CW = $clog2(MAX_BLACK + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLACK);

  logic [ENTRY_W-1:0]   black_mem  [MAX_BLACK];
  logic [ENTRY_W-1:0]   sorted_mem [MAX_BLACK];
  logic [2*ENTRY_W-1:0] remap_mem  [MAX_BLACK];

  in_t                  in_r;
  logic [ENTRY_W-1:0]   bs_q, sa_q, sb_q, x_r;
  logic [2*ENTRY_W-1:0] rm_q;
  logic [CW-1:0]        bcount_r, rc_r, i_r, j_r, jd_r, j0_r, s_r;
  logic [AW-1:0]        rank_r, bs_addr;
  logic                 pv_r;
  logic [V_W-1:0]       v_r;
  logic [RANGE_W-1:0]   range_r, allowed_r, rem_r, cfg_clamp, allowed_new;
  logic [RAND_W-1:0]    w_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [1:0]           load_st_r;
  logic                 out_valid_r;
  out_t                 out_data_r;
  logic [RANGE_W:0]     div_sh, div_sub;
  logic                 rank_less, srch_match;

  assign cfg_clamp   = (cfg_data > RANGE_CAP) ? RANGE_CAP : cfg_data;
  assign allowed_new = (range_r > RANGE_W'(bcount_r)) ? (range_r - RANGE_W'(bcount_r))
                                                      : '0;
  assign bs_addr     = (cmd.op == DP_RANK_SCAN) ? j_r[AW-1:0] : i_r[AW-1:0];
  assign div_sh      = {rem_r, w_r[RAND_W-1]};
  assign div_sub     = div_sh - {1'b0, allowed_r};
  assign rank_less   = (bs_q < x_r) || ((bs_q == x_r) && (jd_r < i_r));
  assign srch_match  = (rm_q[2*ENTRY_W-1:ENTRY_W] == rem_r[ENTRY_W-1:0]);

  assign st.op_pick      = (in_r.operation == OPER_PICK);
  assign st.last         = in_r.entry_last;
  assign st.m_zero       = (bcount_r == '0);
  assign st.allowed_zero = (allowed_r == '0);
  assign st.x_last       = ((i_r + CW'(1)) == bcount_r);
  assign st.scan_done    = (j_r == bcount_r) && !pv_r;
  assign st.skip_go      = (j_r < bcount_r) && (RANGE_W'(sb_q) < allowed_r);
  assign st.map_done     = (i_r == j0_r);
  assign st.map_adv      = (j_r < bcount_r) && (V_W'(sb_q) == v_r);
  assign st.div_last     = (cnt_r == '0);
  assign st.srch_hit     = pv_r && srch_match;
  assign st.srch_done    = (s_r == rc_r) && !pv_r;

  // Memories: every read port runs each cycle, data registered
  always_ff @(posedge clk) begin
    if (cmd.op == DP_STORE && bcount_r < MAX_CNT) begin
      black_mem[bcount_r[AW-1:0]] <= in_r.entry_value;
    end
    bs_q <= black_mem[bs_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_RANK_WR) begin
      sorted_mem[rank_r] <= x_r;
    end
    sa_q <= sorted_mem[i_r[AW-1:0]];
    sb_q <= sorted_mem[j_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_MAP_WR) begin
      remap_mem[rc_r[AW-1:0]] <= {sa_q, v_r[ENTRY_W-1:0]};
    end
    rm_q <= remap_mem[s_r[AW-1:0]];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r     <= RANGE_CAP;
      allowed_r   <= RANGE_CAP;
      bcount_r    <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == DP_EMIT_LOAD) || (cmd.op == DP_EMIT_EMPTY) ||
                     (cmd.op == DP_EMIT_HIT)  || (cmd.op == DP_EMIT_MISS);
      if (cfg_we) begin
        range_r   <= cfg_clamp;
        allowed_r <= cfg_clamp;
        bcount_r  <= '0;
        rc_r      <= '0;
      end else begin
        if (cmd.op == DP_STORE && bcount_r < MAX_CNT) bcount_r <= bcount_r + CW'(1);
        if (cmd.op == DP_BUILD) begin
          allowed_r <= allowed_new;
          rc_r      <= '0;
        end
        if (cmd.op == DP_MAP_WR) rc_r <= rc_r + CW'(1);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    unique case (cmd.op)
      DP_STORE: begin
        load_st_r <= (bcount_r < MAX_CNT) ? ST_ENTRY_OK : ST_STORE_FULL;
        i_r       <= '0;
      end
      DP_RANK_LDX: begin
        x_r    <= bs_q;
        j_r    <= '0;
        rank_r <= '0;
        pv_r   <= 1'b0;
      end
      DP_RANK_SCAN: begin
        pv_r <= (j_r < bcount_r);
        jd_r <= j_r;
        if (j_r < bcount_r) j_r <= j_r + CW'(1);
        if (pv_r && rank_less) rank_r <= rank_r + AW'(1);
      end
      DP_RANK_WR:  i_r <= i_r + CW'(1);
      DP_BUILD: begin
        i_r <= '0;
        j_r <= '0;
      end
      DP_SKIP_ADV: j_r <= j_r + CW'(1);
      DP_SKIP_END: begin
        j0_r <= j_r;
        v_r  <= V_W'(allowed_r);
      end
      DP_MAP_ADV: begin
        j_r <= j_r + CW'(1);
        v_r <= v_r + V_W'(1);
      end
      DP_MAP_WR: begin
        i_r <= i_r + CW'(1);
        v_r <= v_r + V_W'(1);
      end
      DP_DIV_INIT: begin
        rem_r <= '0;
        w_r   <= in_r.random_word;
        cnt_r <= DIV_LAST;
      end
      DP_DIV_STEP: begin
        rem_r <= div_sub[RANGE_W] ? div_sh[RANGE_W-1:0] : div_sub[RANGE_W-1:0];
        w_r   <= w_r << 1;
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
      DP_SRCH_INIT: begin
        s_r  <= '0;
        pv_r <= 1'b0;
      end
      DP_SRCH_STEP: begin
        pv_r <= (s_r < rc_r);
        if (s_r < rc_r) s_r <= s_r + CW'(1);
      end
      DP_EMIT_LOAD: out_data_r <= '{picked_value: '0, status: load_st_r};
      DP_EMIT_EMPTY: out_data_r <= '{picked_value: '0, status: ST_NO_ALLOWED};
      DP_EMIT_HIT: out_data_r <= '{picked_value: rm_q[ENTRY_W-1:0], status: ST_PICK_OK};
      DP_EMIT_MISS: out_data_r <= '{picked_value: rem_r[ENTRY_W-1:0], status: ST_PICK_OK};
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/blacklist_remap_random_pick.sv =====
`timescale 1ns / 1ps
// A load answers after its store step; a pick runs a 31-step restoring divider, then a linear
// search of the remap table, and skips both when no allowed values are left.
// A last entry adds the sort and the table build before the load answers.
// One transaction at a time; busy drops in the cycle the result strobes, so the
// next transaction may start then. Results cannot be stalled.
// Reset (synchronous, active low) empties the list and sets the range to 65536.
// ----------------------------------------------------------------------------
// blacklist_remap_random_pick
// Uniform pick from [0, n) that skips loaded blacklist values via a remap table.
// ----------------------------------------------------------------------------
module blacklist_remap_random_pick
  import blrp_pkg::*;
#(
  parameter int MAX_BLACK = MAX_BLACK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  output logic               out_valid,
  output out_t               out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RANGE_W-1:0] cfg_data
);

  cmd_t cmd;
  st_t  st;
  logic cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  blrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready)
  );

  blrp_dp #(
    .MAX_BLACK (MAX_BLACK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/blrp_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blrp_chk
// Port-level checks on the picker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blrp_chk
  import blrp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data,
  input logic cfg_ready
);

  `CHK_ASSERT_ALL(a_reset_quiet, clk, !rst_n |=> !out_valid && !busy, "not quiet after reset")
  `CHK_ASSERT(a_accept_busy, clk, rst_n, start && !busy |=> busy, "accept did not raise busy")
  `CHK_ASSERT(a_done_idle, clk, rst_n, out_valid |-> !busy && cfg_ready, "result while busy")
  `CHK_ASSERT(a_single, clk, rst_n, out_valid |=> !out_valid, "back-to-back results")
  `CHK_ASSERT(a_zero_pick, clk, rst_n, out_valid && out_data.status != ST_PICK_OK |-> out_data.picked_value == '0, "nonzero value on non-pick status")

endmodule

bind blacklist_remap_random_pick blrp_chk u_chk (.*);

// ===== tb/blacklist_remap_random_pick_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blacklist_remap_random_pick_test
// Drives blacklist loads, table builds and picks through the command port,
// predicts every result with a behavioral model of the remap table, and
// checks each strobed result in order. Range size is rewritten between phases.
// ----------------------------------------------------------------------------
module blacklist_remap_random_pick_test;
  import blrp_pkg::*;

  localparam int NBLACK    = 64;
  localparam int WDOG_MAX  = 20000;
  localparam int SETTLE    = 6000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_t                in_data;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RANGE_W-1:0] cfg_data;

  blacklist_remap_random_pick dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predictor state
  logic [15:0] black_list [NBLACK];
  int          black_num;
  logic [15:0] map_key [NBLACK];
  logic [15:0] map_dst [NBLACK];
  int          map_num;
  int          allowed;
  int          range_n;

  out_t pending_results[$];
  int   error_count;
  int   idle_cycles;
  bit   quiet;

  function automatic int cap_range(int r);
    return (r > (1 << VALUE_BITS)) ? (1 << VALUE_BITS) : r;
  endfunction

  task automatic set_range_model(int r);
    range_n = r;
    black_num = 0;
    map_num = 0;
    allowed = cap_range(r);
  endtask

  task automatic rebuild_remap();
    int srt [NBLACK];
    int m, r, i, j, v, x;
    m = black_num;
    r = cap_range(range_n);
    for (i = 0; i < m; i++) srt[i] = black_list[i];
    for (i = 1; i < m; i++) begin
      x = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > x) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = x;
    end
    allowed = (r > m) ? r - m : 0;
    map_num = 0;
    j = 0;
    while (j < m && srt[j] < allowed) j++;
    v = allowed;
    for (i = 0; i < m && srt[i] < allowed; i++) begin
      while (j < m && srt[j] == v) begin
        j++;
        v++;
      end
      map_key[map_num] = srt[i];
      map_dst[map_num] = v[15:0];
      map_num++;
      v++;
    end
  endtask

  function automatic out_t predict_pick(in_t t);
    out_t o;
    int k;
    o = '0;
    if (t.operation == OPER_LOAD) return o;
    if (allowed == 0) begin
      o.status = ST_NO_ALLOWED;
      return o;
    end
    k = int'({1'b0, t.random_word} % allowed);
    o.status = ST_PICK_OK;
    o.picked_value = k[15:0];
    for (int i = 0; i < map_num; i++) begin
      if (map_key[i] == k) begin
        o.picked_value = map_dst[i];
        break;
      end
    end
    return o;
  endfunction

  task automatic apply_item(in_t t);
    out_t o;
    o = '0;
    if (t.operation == OPER_LOAD) begin
      if (black_num < NBLACK) begin
        black_list[black_num] = t.entry_value;
        black_num++;
        o.status = ST_ENTRY_OK;
      end else begin
        o.status = ST_STORE_FULL;
      end
      if (t.entry_last) rebuild_remap();
    end else begin
      o = predict_pick(t);
    end
    pending_results = {pending_results, o};
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // send one command; random idle burst before it unless quiet
  task automatic send_item(in_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_item(t);
  endtask

  task automatic send_load(logic [15:0] v, logic lst);
    in_t t;
    t.operation = OPER_LOAD;
    t.entry_value = v;
    t.entry_last = lst;
    t.random_word = 31'($urandom);
    send_item(t);
  endtask

  task automatic send_pick(logic [30:0] w);
    in_t t;
    t.operation = OPER_PICK;
    t.entry_value = 16'($urandom);
    t.entry_last = 1'($urandom);
    t.random_word = w;
    send_item(t);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_range(int r);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= RANGE_W'(r);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_range_model(r);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        if (out_data.picked_value !== pending_results[0].picked_value)
          report_mismatch($sformatf("picked_value %0d, expected %0d",
                          out_data.picked_value, pending_results[0].picked_value));
        if (out_data.status !== pending_results[0].status)
          report_mismatch($sformatf("status %0d, expected %0d",
                          out_data.status, pending_results[0].status));
        void'(pending_results.pop_front());
      end
    end
  end

  // watchdog: cycles with no transaction of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("blacklist_remap_random_pick_test: FAIL");
        $finish;
      end
    end
  end

  task automatic test_default_range();
    send_pick('0);
    send_pick('1);
    send_pick(31'd65535);
    send_pick(31'd65536);
  endtask

  task automatic test_small_table();
    write_range(10);
    send_load(16'd2, 1'b0);
    send_load(16'd9, 1'b0);
    send_load(16'd7, 1'b0);
    send_load(16'd0, 1'b1);
    for (int i = 0; i < 6; i++) send_pick(31'(i));
    send_load(16'd9, 1'b1);    // duplicate after a build
    send_pick(31'd3);
    send_pick(31'h7FFFFFFF);
  endtask

  task automatic test_empty_and_zero();
    write_range(0);
    send_pick(31'd5);
    write_range(2);
    send_load(16'd0, 1'b0);
    send_load(16'd65535, 1'b1);
    send_pick(31'd1);
    write_range(1);
    send_load(16'd0, 1'b1);
    send_pick(31'd0);
  endtask

  task automatic test_store_full();
    write_range(131071);       // oversized, clamps
    for (int i = 0; i < NBLACK; i++) send_load(16'($urandom_range(0, 200)), 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'h1234, 1'b1);
    for (int i = 0; i < 8; i++) send_pick(31'($urandom_range(0, 300)));
  endtask

  task automatic test_random();
    int sizes [6] = '{1, 5, 70, 300, 65536, 131071};
    int items, r, n;
    items = 0;
    for (int ph = 0; items < 1200; ph++) begin
      if (ph % 4 == 0) r = sizes[$urandom_range(0, 5)];
      else r = $urandom_range(1, 400);
      write_range(r);
      if (items > 1050) quiet = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) send_load(16'($urandom), 1'b0);
        else send_load(16'($urandom_range(0, (r > 65536 ? 65536 : r) - 1)), 1'b0);
        items++;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_load(16'($urandom_range(0, 65535) % (r > 65536 ? 65536 : r)), 1'b1);
        items++;
      end
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 19) == 0) send_load(16'($urandom), 1'($urandom));
        else if ($urandom_range(0, 1)) send_pick(31'($urandom_range(0, 2 * r)));
        else send_pick(31'($urandom));
        items++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    error_count = 0;
    quiet = 1'b0;
    set_range_model(65536);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_range();
    test_small_table();
    test_empty_and_zero();
    test_store_full();
    test_random();
    drain();
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("blacklist_remap_random_pick_test: PASS");
    end else begin
      $display("blacklist_remap_random_pick_test: FAIL");
    end
    $finish;
  end

endmodule
